### design/fixed_block_free_list_allocator_core_assert.svh
// Assertion macros used by the checker file.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define FBFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define FBFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/fbfl_pkg.sv
`default_nettype none
package fbfl_pkg;

  localparam int NUM_BLOCKS      = 256;
  localparam int MAX_BLOCK_BYTES = 4096;
  localparam int MIN_BLOCK_BYTES = 8;

  localparam int IDX_W  = 8;
  localparam int NEXT_W = 9;
  localparam int CNT_W  = 9;
  localparam int SIZE_W = 13;
  localparam int OFF_W  = 20;
  localparam int CFG_ADDR_W = 2;

  localparam logic [NEXT_W-1:0] LIST_END = NEXT_W'(NUM_BLOCKS);

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_NULL  = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_SIZE  = 2'd1;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             has_block;
    logic [IDX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted_index;
    logic [OFF_W-1:0] granted_offset;
  } rsp_t;

endpackage
`default_nettype wire

### design/fixed_block_free_list_allocator_core.sv
// Alloc: the head's next entry is read into a register, then S_READ registers the result;
//   free, init, unused command and alloc on an empty pool answer in the cycle after acceptance.
// Throughput: alloc blocks input in its head read; others one per cycle if the output is free.
// Reset: asynchronous, active low; chain is linked by clearing per-entry written flags,
//   no clearing pass. Init relinks the same way.
`default_nettype none
module fixed_block_free_list_allocator_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire fbfl_pkg::req_t                  in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output fbfl_pkg::rsp_t                       out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [fbfl_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [fbfl_pkg::SIZE_W-1:0]     cfg_data_i
);
  import fbfl_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                  state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  out_data_q, out_data_d;
  logic [NEXT_W-1:0]     head_q, head_d;
  logic [IDX_W-1:0]      last_q, last_d;
  logic [CNT_W-1:0]      count_q;
  logic [SIZE_W-1:0]     size_q;
  logic [NUM_BLOCKS-1:0] written_q;

  logic [NEXT_W-1:0]     mem [NUM_BLOCKS];
  logic [NEXT_W-1:0]     rdata_q;
  logic [IDX_W-1:0]      rd_addr_q;
  logic                  rd_written_q;

  logic                  in_fire, cfg_fire;
  logic                  mem_we, mem_re, relink;
  logic [NEXT_W-1:0]     next_blk;
  logic [20:0]           prod;
  logic [CNT_W-1:0]      cnt_wr;
  logic [SIZE_W-1:0]     size_wr;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Unwritten entries read as the linked chain ending at last_q.
  always_comb begin
    if (rd_written_q) begin
      next_blk = rdata_q;
    end else if (rd_addr_q == last_q) begin
      next_blk = LIST_END;
    end else begin
      next_blk = {1'b0, rd_addr_q} + NEXT_W'(1);
    end
  end

  assign prod = 21'(rd_addr_q) * 21'(size_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    relink      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          case (in_data_i.cmd)
            CMD_ALLOC: begin
              if (head_q[NEXT_W-1]) begin
                out_data_d.status = STAT_EMPTY;
              end else begin
                // hold the result until the head entry is back
                out_valid_d = 1'b0;
                mem_re      = 1'b1;
                state_d     = S_READ;
              end
            end
            CMD_FREE: begin
              if (!in_data_i.has_block) begin
                out_data_d.status = STAT_NULL;
              end else if ({1'b0, in_data_i.block_index} >= count_q) begin
                out_data_d.status = STAT_RANGE;
              end else begin
                mem_we = 1'b1;
                head_d = {1'b0, in_data_i.block_index};
              end
            end
            CMD_INIT: begin
              relink = 1'b1;
              head_d = '0;
              last_d = IDX_W'(count_q - CNT_W'(1));
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        head_d                    = next_blk;
        out_valid_d               = 1'b1;
        out_data_d.status         = STAT_OK;
        out_data_d.granted_index  = rd_addr_q;
        out_data_d.granted_offset = prod[OFF_W-1:0];
        state_d                   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Clamp register writes into their legal ranges.
  always_comb begin
    cnt_wr = cfg_data_i[CNT_W-1:0];
    if (cnt_wr == '0) begin
      cnt_wr = CNT_W'(1);
    end else if (cnt_wr > CNT_W'(NUM_BLOCKS)) begin
      cnt_wr = CNT_W'(NUM_BLOCKS);
    end
    size_wr = cfg_data_i;
    if (size_wr < SIZE_W'(MIN_BLOCK_BYTES)) begin
      size_wr = SIZE_W'(MIN_BLOCK_BYTES);
    end else if (size_wr > SIZE_W'(MAX_BLOCK_BYTES)) begin
      size_wr = SIZE_W'(MAX_BLOCK_BYTES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      last_q      <= IDX_W'(NUM_BLOCKS - 1);
      count_q     <= CNT_W'(NUM_BLOCKS);
      size_q      <= SIZE_W'(MIN_BLOCK_BYTES);
      written_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      last_q      <= last_d;
      if (relink) begin
        written_q <= '0;
      end else if (mem_we) begin
        written_q[in_data_i.block_index] <= 1'b1;
      end
      if (cfg_fire && (cfg_addr_i == REG_BLOCK_COUNT)) begin
        count_q <= cnt_wr;
      end
      if (cfg_fire && (cfg_addr_i == REG_BLOCK_SIZE)) begin
        size_q <= size_wr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[in_data_i.block_index] <= head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q      <= mem[head_q[IDX_W-1:0]];
      rd_addr_q    <= head_q[IDX_W-1:0];
      rd_written_q <= written_q[head_q[IDX_W-1:0]];
    end
  end

endmodule
`default_nettype wire

### design/fbfl_checker.sv
`default_nettype none
`include "fixed_block_free_list_allocator_core_assert.svh"
module fbfl_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire fbfl_pkg::req_t                  in_data_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire fbfl_pkg::rsp_t                  out_data_o
);
  import fbfl_pkg::*;

  `FBFL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(out_data_o), "result changed while stalled")

  `FBFL_ASSERT_NOW(a_err_zero, out_valid_o && (out_data_o.status != STAT_OK),
                   (out_data_o.granted_index == '0) && (out_data_o.granted_offset == '0),
                   "error result carries nonzero grant")

  // block size is at least the minimum, so the offset never falls below index * 8
  `FBFL_ASSERT_NOW(a_off_floor, out_valid_o && (out_data_o.status == STAT_OK),
                   out_data_o.granted_offset >= OFF_W'({out_data_o.granted_index, 3'b000}),
                   "offset below index times the minimum block size")

  // a non-empty alloc holds the input for the head read; an empty one answers at once
  `FBFL_ASSERT_NEXT(a_alloc_busy, in_valid_i && in_ready_o && (in_data_i.cmd == CMD_ALLOC),
                    !in_ready_o || (out_valid_o && (out_data_o.status == STAT_EMPTY)),
                    "transaction taken during alloc head read")

endmodule

bind fixed_block_free_list_allocator_core fbfl_checker u_fbfl_checker (.*);
`default_nettype wire
